// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/lzo_pkg.sv =====
// ----------------------------------------------------------------------------
// lzo_pkg
// Types and constants shared by the layer z-order sequencer and datapath.
// ----------------------------------------------------------------------------
package lzo_pkg;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_SETH  = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_SLOT   = 2'd2;

  // Height value meaning hidden / no visible layer
  localparam logic signed [8:0] HIDDEN = -9'sd1;

  // Datapath operations selected by the control word
  typedef enum logic [4:0] {
    ACT_NOP         = 5'd0,
    ACT_LATCH       = 5'd1,
    ACT_INC_H       = 5'd2,
    ACT_ALLOC_OK    = 5'd3,
    ACT_RES_NOFREE  = 5'd4,
    ACT_RD_OT_SLOT  = 5'd5,
    ACT_RD_HT_OT    = 5'd6,
    ACT_RES_READ    = 5'd7,
    ACT_RES_SLOTERR = 5'd8,
    ACT_RES_IGN     = 5'd9,
    ACT_RD_HT_ID    = 5'd10,
    ACT_LOAD_OLD    = 5'd11,
    ACT_WR_HT_ID    = 5'd12,
    ACT_SET_H_OLD   = 5'd13,
    ACT_SET_H_TOP   = 5'd14,
    ACT_RD_OT_HM1   = 5'd15,
    ACT_MOVE_DN     = 5'd16,
    ACT_WR_OT_ID    = 5'd17,
    ACT_RD_OT_HP1   = 5'd18,
    ACT_MOVE_UP     = 5'd19,
    ACT_DEC_TOP     = 5'd20,
    ACT_RD_OT_H     = 5'd21,
    ACT_MOVE_REV    = 5'd22,
    ACT_WR_OT_ID_INC = 5'd23,
    ACT_FINISH      = 5'd24,
    ACT_PUSH        = 5'd25
  } act_e;

  // Branch conditions tested by the sequencer
  typedef enum logic [4:0] {
    CND_ALWAYS     = 5'd0,
    CND_IN_VALID   = 5'd1,
    CND_CMD_ALLOC  = 5'd2,
    CND_CMD_READ   = 5'd3,
    CND_H_FREE     = 5'd4,
    CND_H_LAST     = 5'd5,
    CND_SLOT_BAD   = 5'd6,
    CND_ID_SKIP    = 5'd7,
    CND_HT_EQ_OLD  = 5'd8,
    CND_OLD_GT_HT  = 5'd9,
    CND_HT_NEG     = 5'd10,
    CND_OLD_NEG    = 5'd11,
    CND_H_LT_TOP   = 5'd12,
    CND_HM1_GT_HT  = 5'd13,
    CND_HP1_LT_TOP = 5'd14,
    CND_HP1_LT_HT  = 5'd15,
    CND_TOP_GE_HT  = 5'd16,
    CND_HM1_GE_HT  = 5'd17,
    CND_OUT_FREE   = 5'd18
  } cond_e;

  // Program steps
  typedef enum logic [5:0] {
    SP_IDLE  = 6'd0,
    SP_DISP  = 6'd1,
    SP_DISP2 = 6'd2,
    SP_A0    = 6'd3,
    SP_A1    = 6'd4,
    SP_AOK   = 6'd5,
    SP_AFAIL = 6'd6,
    SP_RD0   = 6'd7,
    SP_RD1   = 6'd8,
    SP_RD2   = 6'd9,
    SP_RD3   = 6'd10,
    SP_RFAIL = 6'd11,
    SP_P0    = 6'd12,
    SP_IGN   = 6'd13,
    SP_P1    = 6'd14,
    SP_P2    = 6'd15,
    SP_P3    = 6'd16,
    SP_P4    = 6'd17,
    SP_PD    = 6'd18,
    SP_L1    = 6'd19,
    SP_L2    = 6'd20,
    SP_LEND  = 6'd21,
    SP_H0    = 6'd22,
    SP_H1    = 6'd23,
    SP_H2    = 6'd24,
    SP_HEND  = 6'd25,
    SP_PU    = 6'd26,
    SP_R1    = 6'd27,
    SP_R2    = 6'd28,
    SP_V0    = 6'd29,
    SP_V1    = 6'd30,
    SP_V2    = 6'd31,
    SP_VEND  = 6'd32,
    SP_FIN   = 6'd33,
    SP_EMIT  = 6'd34
  } step_e;

  // One control word of the program
  typedef struct packed {
    act_e  act;
    cond_e cnd;
    step_e tgt_t;
    step_e tgt_f;
  } ucode_t;

  // Control from sequencer to datapath
  typedef struct packed {
    act_e act;
  } ctrl_t;

  // Condition flags from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic cmd_alloc;
    logic cmd_read;
    logic h_free;
    logic h_last;
    logic slot_bad;
    logic id_skip;
    logic ht_eq_old;
    logic old_gt_ht;
    logic ht_neg;
    logic old_neg;
    logic h_lt_top;
    logic hm1_gt_ht;
    logic hp1_lt_top;
    logic hp1_lt_ht;
    logic top_ge_ht;
    logic hm1_ge_ht;
    logic out_free;
  } flags_t;

endpackage

// ===== hdl/layer_z_order_manager.sv =====
// ----------------------------------------------------------------------------
// layer_z_order_manager
// Display layer pool and stacking-order list, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per
//   transaction: allocate, set height, free or read slot. Output channel
//   (out_valid_o / out_stall_i) carries exactly one result per command.
//   One command is worked on at a time; in_stall_o is low only while the
//   sequencer waits, from the cycle after a result is loaded onwards.
//   Allocate scans the layers from index 0 for the first free one. A set
//   height or free of a layer that is not allocated is ignored, and one
//   that leaves the height unchanged shifts nothing; else the shift loop
//   moves the layers between the old and the new height, with one order
//   table read and then one write of both the order table and the height
//   memory per table entry.
//   After reset no layer is allocated and the top index is -1; heights are
//   set hidden on allocation; the order table needs no clearing pass.
//   The result sits in an output register; a stalled result is held and
//   the next command is accepted meanwhile, but its own result waits.
// ----------------------------------------------------------------------------
module layer_z_order_manager #(
  parameter int NUM_LAYERS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [7:0]        layer_i,
  input  logic signed [8:0] new_height_i,
  input  logic [7:0]        slot_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [7:0]        layer_id_o,
  output logic signed [8:0] layer_height_o,
  output logic signed [8:0] top_index_o,
  output logic              repaint_o
);
  import lzo_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  // Sequencer
  lzo_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flags_i    (flags),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  // Datapath
  lzo_dp #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .flags_o        (flags),
    .in_valid_i     (in_valid_i),
    .command_i      (command_i),
    .layer_i        (layer_i),
    .new_height_i   (new_height_i),
    .slot_i         (slot_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .layer_id_o     (layer_id_o),
    .layer_height_o (layer_height_o),
    .top_index_o    (top_index_o),
    .repaint_o      (repaint_o)
  );

endmodule

// ===== hdl/lzo_seq.sv =====
// ----------------------------------------------------------------------------
// lzo_seq
// Step counter and control store; branches on datapath flags.
// ----------------------------------------------------------------------------
module lzo_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lzo_pkg::flags_t flags_i,
  output lzo_pkg::ctrl_t  ctrl_o,
  output logic            in_stall_o
);
  import lzo_pkg::*;

  step_e  step_q, step_d;
  ucode_t uw;
  logic   cnd_ok;

  function automatic ucode_t w(act_e a, cond_e c, step_e t, step_e f);
    ucode_t r;
    r.act   = a;
    r.cnd   = c;
    r.tgt_t = t;
    r.tgt_f = f;
    return r;
  endfunction

  // Control store: one word per step
  function automatic ucode_t rom(step_e s);
    ucode_t r;
    case (s)
      SP_IDLE:  r = w(ACT_LATCH,        CND_IN_VALID,   SP_DISP,  SP_IDLE);
      SP_DISP:  r = w(ACT_NOP,          CND_CMD_ALLOC,  SP_A0,    SP_DISP2);
      SP_DISP2: r = w(ACT_NOP,          CND_CMD_READ,   SP_RD0,   SP_P0);
      SP_A0:    r = w(ACT_NOP,          CND_H_FREE,     SP_AOK,   SP_A1);
      SP_A1:    r = w(ACT_INC_H,        CND_H_LAST,     SP_AFAIL, SP_A0);
      SP_AOK:   r = w(ACT_ALLOC_OK,     CND_ALWAYS,     SP_EMIT,  SP_EMIT);
      SP_AFAIL: r = w(ACT_RES_NOFREE,   CND_ALWAYS,     SP_EMIT,  SP_EMIT);
      SP_RD0:   r = w(ACT_NOP,          CND_SLOT_BAD,   SP_RFAIL, SP_RD1);
      SP_RD1:   r = w(ACT_RD_OT_SLOT,   CND_ALWAYS,     SP_RD2,   SP_RD2);
      SP_RD2:   r = w(ACT_RD_HT_OT,     CND_ALWAYS,     SP_RD3,   SP_RD3);
      SP_RD3:   r = w(ACT_RES_READ,     CND_ALWAYS,     SP_EMIT,  SP_EMIT);
      SP_RFAIL: r = w(ACT_RES_SLOTERR,  CND_ALWAYS,     SP_EMIT,  SP_EMIT);
      SP_P0:    r = w(ACT_NOP,          CND_ID_SKIP,    SP_IGN,   SP_P1);
      SP_IGN:   r = w(ACT_RES_IGN,      CND_ALWAYS,     SP_EMIT,  SP_EMIT);
      SP_P1:    r = w(ACT_RD_HT_ID,     CND_ALWAYS,     SP_P2,    SP_P2);
      SP_P2:    r = w(ACT_LOAD_OLD,     CND_ALWAYS,     SP_P3,    SP_P3);
      SP_P3:    r = w(ACT_NOP,          CND_HT_EQ_OLD,  SP_FIN,   SP_P4);
      SP_P4:    r = w(ACT_WR_HT_ID,     CND_OLD_GT_HT,  SP_PD,    SP_PU);
      SP_PD:    r = w(ACT_SET_H_OLD,    CND_HT_NEG,     SP_H0,    SP_L1);
      SP_L1:    r = w(ACT_RD_OT_HM1,    CND_ALWAYS,     SP_L2,    SP_L2);
      SP_L2:    r = w(ACT_MOVE_DN,      CND_HM1_GT_HT,  SP_L1,    SP_LEND);
      SP_LEND:  r = w(ACT_WR_OT_ID,     CND_ALWAYS,     SP_FIN,   SP_FIN);
      SP_H0:    r = w(ACT_NOP,          CND_H_LT_TOP,   SP_H1,    SP_HEND);
      SP_H1:    r = w(ACT_RD_OT_HP1,    CND_ALWAYS,     SP_H2,    SP_H2);
      SP_H2:    r = w(ACT_MOVE_UP,      CND_HP1_LT_TOP, SP_H1,    SP_HEND);
      SP_HEND:  r = w(ACT_DEC_TOP,      CND_ALWAYS,     SP_FIN,   SP_FIN);
      SP_PU:    r = w(ACT_SET_H_OLD,    CND_OLD_NEG,    SP_V0,    SP_R1);
      SP_R1:    r = w(ACT_RD_OT_HP1,    CND_ALWAYS,     SP_R2,    SP_R2);
      SP_R2:    r = w(ACT_MOVE_UP,      CND_HP1_LT_HT,  SP_R1,    SP_LEND);
      SP_V0:    r = w(ACT_SET_H_TOP,    CND_TOP_GE_HT,  SP_V1,    SP_VEND);
      SP_V1:    r = w(ACT_RD_OT_H,      CND_ALWAYS,     SP_V2,    SP_V2);
      SP_V2:    r = w(ACT_MOVE_REV,     CND_HM1_GE_HT,  SP_V1,    SP_VEND);
      SP_VEND:  r = w(ACT_WR_OT_ID_INC, CND_ALWAYS,     SP_FIN,   SP_FIN);
      SP_FIN:   r = w(ACT_FINISH,       CND_ALWAYS,     SP_EMIT,  SP_EMIT);
      SP_EMIT:  r = w(ACT_PUSH,         CND_OUT_FREE,   SP_IDLE,  SP_EMIT);
      default:  r = w(ACT_NOP,          CND_ALWAYS,     SP_IDLE,  SP_IDLE);
    endcase
    return r;
  endfunction

  assign uw = rom(step_q);

  // Select the branch condition
  always_comb begin
    case (uw.cnd)
      CND_ALWAYS:     cnd_ok = 1'b1;
      CND_IN_VALID:   cnd_ok = flags_i.in_valid;
      CND_CMD_ALLOC:  cnd_ok = flags_i.cmd_alloc;
      CND_CMD_READ:   cnd_ok = flags_i.cmd_read;
      CND_H_FREE:     cnd_ok = flags_i.h_free;
      CND_H_LAST:     cnd_ok = flags_i.h_last;
      CND_SLOT_BAD:   cnd_ok = flags_i.slot_bad;
      CND_ID_SKIP:    cnd_ok = flags_i.id_skip;
      CND_HT_EQ_OLD:  cnd_ok = flags_i.ht_eq_old;
      CND_OLD_GT_HT:  cnd_ok = flags_i.old_gt_ht;
      CND_HT_NEG:     cnd_ok = flags_i.ht_neg;
      CND_OLD_NEG:    cnd_ok = flags_i.old_neg;
      CND_H_LT_TOP:   cnd_ok = flags_i.h_lt_top;
      CND_HM1_GT_HT:  cnd_ok = flags_i.hm1_gt_ht;
      CND_HP1_LT_TOP: cnd_ok = flags_i.hp1_lt_top;
      CND_HP1_LT_HT:  cnd_ok = flags_i.hp1_lt_ht;
      CND_TOP_GE_HT:  cnd_ok = flags_i.top_ge_ht;
      CND_HM1_GE_HT:  cnd_ok = flags_i.hm1_ge_ht;
      CND_OUT_FREE:   cnd_ok = flags_i.out_free;
      default:        cnd_ok = 1'b0;
    endcase
  end

  assign step_d     = cnd_ok ? uw.tgt_t : uw.tgt_f;
  assign ctrl_o.act = uw.act;
  assign in_stall_o = (step_q != SP_IDLE);

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= SP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== hdl/lzo_dp.sv =====
// ----------------------------------------------------------------------------
// lzo_dp
// Datapath: order table and height memories, pool bits, working registers
// and the output register.
// ----------------------------------------------------------------------------
module lzo_dp #(
  parameter int NUM_LAYERS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzo_pkg::ctrl_t      ctrl_i,
  output lzo_pkg::flags_t     flags_o,
  input  logic                in_valid_i,
  input  logic [1:0]          command_i,
  input  logic [7:0]          layer_i,
  input  logic signed [8:0]   new_height_i,
  input  logic [7:0]          slot_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [7:0]          layer_id_o,
  output logic signed [8:0]   layer_height_o,
  output logic signed [8:0]   top_index_o,
  output logic                repaint_o
);
  import lzo_pkg::*;

  localparam int AW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

  // Memories
  logic [7:0]        ot_mem [NUM_LAYERS];
  logic signed [8:0] ht_mem [NUM_LAYERS];

  // Working registers
  logic [1:0]        cmd_q;
  logic [7:0]        id_q, slot_q, ot_rdata_q;
  logic signed [8:0] req_q, old_q, ht_q, h_q, ht_rdata_q;
  logic              rp_q;
  logic [1:0]        res_status_q;
  logic [7:0]        res_id_q;
  logic signed [8:0] res_height_q;

  // Control state
  logic [NUM_LAYERS-1:0] in_use_q;
  logic signed [8:0]     top_q;
  logic                  out_valid_q;

  // Output register
  logic [1:0]        out_status_q;
  logic [7:0]        out_id_q;
  logic signed [8:0] out_height_q, out_top_q;
  logic              out_rp_q;

  // Memory port controls
  logic              ot_we, ot_re, ht_we, ht_re;
  logic [AW-1:0]     ot_waddr, ot_raddr, ht_waddr, ht_raddr;
  logic [7:0]        ot_wdata;
  logic signed [8:0] ht_wdata;

  logic [AW-1:0]     h_idx, hp1_idx, hm1_idx, id_idx;
  logic signed [8:0] hp1, hm1, req_eff;
  logic signed [9:0] hx, htx, topx, oldx;
  logic              out_free;

  function automatic logic signed [9:0] sx(logic signed [8:0] v);
    return {v[8], v};
  endfunction

  // Clamp a requested height to the range from hidden up to the current top (one past it for a hidden layer)
  function automatic logic signed [8:0] clamp(logic signed [8:0] r,
                                              logic signed [8:0] o,
                                              logic signed [8:0] t);
    logic signed [9:0] lim, v;
    lim = o[8] ? (sx(t) + 10'sd1) : sx(t);
    v   = (sx(r) > lim) ? lim : sx(r);
    if (v < -10'sd1) v = -10'sd1;
    return v[8:0];
  endfunction

  assign hp1     = h_q + 9'sd1;
  assign hm1     = h_q - 9'sd1;
  assign h_idx   = h_q[AW-1:0];
  assign hp1_idx = hp1[AW-1:0];
  assign hm1_idx = hm1[AW-1:0];
  assign id_idx  = id_q[AW-1:0];
  assign req_eff = (cmd_q == CMD_FREE) ? HIDDEN : req_q;
  assign hx      = sx(h_q);
  assign htx     = sx(ht_q);
  assign topx    = sx(top_q);
  assign oldx    = sx(old_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // Condition flags
  always_comb begin
    flags_o.in_valid   = in_valid_i;
    flags_o.cmd_alloc  = (cmd_q == CMD_ALLOC);
    flags_o.cmd_read   = (cmd_q == CMD_READ);
    flags_o.h_free     = !in_use_q[h_idx];
    flags_o.h_last     = (h_q == 9'(NUM_LAYERS - 1));
    flags_o.slot_bad   = ($signed({2'b00, slot_q}) > topx) ||
                         ({1'b0, slot_q} >= 9'(NUM_LAYERS));
    flags_o.id_skip    = ({1'b0, id_q} >= 9'(NUM_LAYERS)) || !in_use_q[id_idx];
    flags_o.ht_eq_old  = (ht_q == old_q);
    flags_o.old_gt_ht  = (oldx > htx);
    flags_o.ht_neg     = ht_q[8];
    flags_o.old_neg    = old_q[8];
    flags_o.h_lt_top   = (hx < topx);
    flags_o.hm1_gt_ht  = (hx > (htx + 10'sd1));
    flags_o.hp1_lt_top = ((hx + 10'sd1) < topx);
    flags_o.hp1_lt_ht  = ((hx + 10'sd1) < htx);
    flags_o.top_ge_ht  = (topx >= htx);
    flags_o.hm1_ge_ht  = (hx > htx);
    flags_o.out_free   = out_free;
  end

  // Steer the memory ports
  always_comb begin
    ot_we    = 1'b0;
    ot_waddr = h_idx;
    ot_wdata = ot_rdata_q;
    ot_re    = 1'b0;
    ot_raddr = h_idx;
    ht_we    = 1'b0;
    ht_waddr = id_idx;
    ht_wdata = ht_q;
    ht_re    = 1'b0;
    ht_raddr = id_idx;
    case (ctrl_i.act)
      ACT_ALLOC_OK: begin
        ht_we    = 1'b1;
        ht_waddr = h_idx;
        ht_wdata = HIDDEN;
      end
      ACT_RD_OT_SLOT: begin
        ot_re    = 1'b1;
        ot_raddr = slot_q[AW-1:0];
      end
      ACT_RD_HT_OT: begin
        ht_re    = 1'b1;
        ht_raddr = ot_rdata_q[AW-1:0];
      end
      ACT_RD_HT_ID: begin
        ht_re = 1'b1;
      end
      ACT_WR_HT_ID: begin
        ht_we = 1'b1;
      end
      ACT_RD_OT_HM1: begin
        ot_re    = 1'b1;
        ot_raddr = hm1_idx;
      end
      ACT_RD_OT_HP1: begin
        ot_re    = 1'b1;
        ot_raddr = hp1_idx;
      end
      ACT_RD_OT_H: begin
        ot_re = 1'b1;
      end
      ACT_MOVE_DN, ACT_MOVE_UP: begin
        ot_we    = 1'b1;
        ht_we    = 1'b1;
        ht_waddr = ot_rdata_q[AW-1:0];
        ht_wdata = h_q;
      end
      ACT_MOVE_REV: begin
        ot_we    = 1'b1;
        ot_waddr = hp1_idx;
        ht_we    = 1'b1;
        ht_waddr = ot_rdata_q[AW-1:0];
        ht_wdata = hp1;
      end
      ACT_WR_OT_ID, ACT_WR_OT_ID_INC: begin
        ot_we    = 1'b1;
        ot_waddr = ht_q[AW-1:0];
        ot_wdata = id_q;
      end
      default: ;
    endcase
  end

  // Order table memory
  always_ff @(posedge clk_i) begin
    if (ot_we) ot_mem[ot_waddr] <= ot_wdata;
    if (ot_re) ot_rdata_q <= ot_mem[ot_raddr];
  end

  // Height memory
  always_ff @(posedge clk_i) begin
    if (ht_we) ht_mem[ht_waddr] <= ht_wdata;
    if (ht_re) ht_rdata_q <= ht_mem[ht_raddr];
  end

  // Working registers and result fields
  always_ff @(posedge clk_i) begin
    case (ctrl_i.act)
      ACT_LATCH: begin
        if (in_valid_i) begin
          cmd_q  <= command_i;
          id_q   <= layer_i;
          req_q  <= new_height_i;
          slot_q <= slot_i;
          h_q    <= '0;
          rp_q   <= 1'b0;
        end
      end
      ACT_INC_H:     h_q <= hp1;
      ACT_ALLOC_OK: begin
        res_status_q <= ST_OK;
        res_id_q     <= h_q[7:0];
        res_height_q <= HIDDEN;
      end
      ACT_RES_NOFREE: begin
        res_status_q <= ST_NOFREE;
        res_id_q     <= '0;
        res_height_q <= HIDDEN;
      end
      ACT_RES_SLOTERR: begin
        res_status_q <= ST_SLOT;
        res_id_q     <= '0;
        res_height_q <= HIDDEN;
      end
      ACT_RES_IGN: begin
        res_status_q <= ST_OK;
        res_id_q     <= id_q;
        res_height_q <= HIDDEN;
      end
      ACT_RES_READ: begin
        res_status_q <= ST_OK;
        res_id_q     <= ot_rdata_q;
        res_height_q <= ht_rdata_q;
      end
      ACT_LOAD_OLD: begin
        old_q <= ht_rdata_q;
        ht_q  <= clamp(req_eff, ht_rdata_q, top_q);
      end
      ACT_WR_HT_ID:  rp_q <= 1'b1;
      ACT_SET_H_OLD: h_q <= old_q;
      ACT_SET_H_TOP: h_q <= top_q;
      ACT_MOVE_DN:   h_q <= hm1;
      ACT_MOVE_UP:   h_q <= hp1;
      ACT_MOVE_REV:  h_q <= hm1;
      ACT_FINISH: begin
        res_status_q <= ST_OK;
        res_id_q     <= id_q;
        res_height_q <= ht_q;
      end
      default: ;
    endcase
  end

  // Load the output register when it is free
  always_ff @(posedge clk_i) begin
    if (ctrl_i.act == ACT_PUSH && out_free) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_height_q <= res_height_q;
      out_top_q    <= top_q;
      out_rp_q     <= rp_q;
    end
  end

  // Pool bits, top position and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      top_q       <= HIDDEN;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.act == ACT_ALLOC_OK) in_use_q[h_idx] <= 1'b1;
      if (ctrl_i.act == ACT_FINISH && cmd_q == CMD_FREE) in_use_q[id_idx] <= 1'b0;
      if (ctrl_i.act == ACT_DEC_TOP) top_q <= top_q - 9'sd1;
      if (ctrl_i.act == ACT_WR_OT_ID_INC) top_q <= top_q + 9'sd1;
      if (ctrl_i.act == ACT_PUSH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign layer_id_o     = out_id_q;
  assign layer_height_o = out_height_q;
  assign top_index_o    = out_top_q;
  assign repaint_o      = out_rp_q;

endmodule

// ===== hdl/lzo_checker.sv =====
// ----------------------------------------------------------------------------
// lzo_checker
// Port-level checks on the layer z-order manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzo_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [1:0]        command_i,
  input logic [7:0]        layer_i,
  input logic signed [8:0] new_height_i,
  input logic [7:0]        slot_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        status_o,
  input logic [7:0]        layer_id_o,
  input logic signed [8:0] layer_height_o,
  input logic signed [8:0] top_index_o,
  input logic              repaint_o
);
  import lzo_pkg::*;

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(layer_id_o) && $stable(layer_height_o) && $stable(top_index_o) && $stable(repaint_o))

  // Stall the input once a command has been taken
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // Error results carry no layer and request no repaint
  `ASSERT_IMPLIES(a_err_fields, clk_i, rst_ni, out_valid_o && (status_o != ST_OK), (layer_id_o == 8'd0) && (layer_height_o == HIDDEN) && !repaint_o)

  // Negative heights and top index are only ever the hidden marker
  `ASSERT_IMPLIES(a_neg_is_hidden, clk_i, rst_ni, out_valid_o, (!top_index_o[8] || (top_index_o == HIDDEN)) && (!layer_height_o[8] || (layer_height_o == HIDDEN)))

endmodule

bind layer_z_order_manager lzo_checker u_lzo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .command_i      (command_i),
  .layer_i        (layer_i),
  .new_height_i   (new_height_i),
  .slot_i         (slot_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .layer_id_o     (layer_id_o),
  .layer_height_o (layer_height_o),
  .top_index_o    (top_index_o),
  .repaint_o      (repaint_o)
);
